// File: rtl/core/dtmf_spd_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions shared by the DTMF spectral peak detector.
package dtmf_spd_pkg;

   localparam int FRAME_BINS = 4096;
   localparam logic [11:0] LAST_BIN = 12'(FRAME_BINS - 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int VOTE_SLOTS = 10;

   localparam logic [3:0]  VOTE_MAX = 4'd15;

   localparam logic [3:0]  RESET_FRAMES_PER_WINDOW   = 4'd5;
   localparam logic [11:0] RESET_LOW_BAND_FIRST_BIN  = 12'd60;
   localparam logic [11:0] RESET_LOW_BAND_LAST_BIN   = 12'd80;
   localparam logic [11:0] RESET_HIGH_BAND_FIRST_BIN = 12'd104;
   localparam logic [11:0] RESET_HIGH_BAND_LAST_BIN  = 12'd126;

   // Row (low group) and column (high group) bins of the keypad.
   localparam logic [11:0] ROW_BIN_0 = 12'd60;
   localparam logic [11:0] ROW_BIN_1 = 12'd66;
   localparam logic [11:0] ROW_BIN_2 = 12'd73;
   localparam logic [11:0] ROW_BIN_3 = 12'd80;
   localparam logic [11:0] COL_BIN_0 = 12'd104;
   localparam logic [11:0] COL_BIN_1 = 12'd114;
   localparam logic [11:0] COL_BIN_2 = 12'd126;

   localparam logic [1:0] ZERO_ROW = 2'd3;
   localparam logic [1:0] ZERO_COL = 2'd1;
   localparam logic [3:0] NO_DIGIT = 4'd0;

   typedef enum logic [2:0] {
      REG_FRAMES_PER_WINDOW   = 3'd0,
      REG_LOW_BAND_FIRST_BIN  = 3'd1,
      REG_LOW_BAND_LAST_BIN   = 3'd2,
      REG_HIGH_BAND_FIRST_BIN = 3'd3,
      REG_HIGH_BAND_LAST_BIN  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [11:0] bin_index;
      logic [31:0] bin_magnitude;
   } req_type;

   typedef struct packed {
      logic       tone_found;
      logic [3:0] digit;
      logic [3:0] vote_total;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] digit;
   } match_type;

   typedef struct packed {
      logic [3:0] votes;
      logic [3:0] digit;
   } leader_type;

   // Map a low/high peak bin pair onto a keypad digit.
   function automatic match_type match_digit(input logic [11:0] lbin, input logic [11:0] hbin);
      match_type  m;
      logic [1:0] row;
      logic [1:0] col;
      logic       row_ok;
      logic       col_ok;
      row    = 2'd0;
      col    = 2'd0;
      row_ok = 1'b1;
      col_ok = 1'b1;
      case (lbin)
         ROW_BIN_0: row = 2'd0;
         ROW_BIN_1: row = 2'd1;
         ROW_BIN_2: row = 2'd2;
         ROW_BIN_3: row = 2'd3;
         default:   row_ok = 1'b0;
      endcase
      case (hbin)
         COL_BIN_0: col = 2'd0;
         COL_BIN_1: col = 2'd1;
         COL_BIN_2: col = 2'd2;
         default:   col_ok = 1'b0;
      endcase
      if (row == ZERO_ROW) begin
         // bottom row only carries digit zero, in the middle column
         m.hit   = row_ok && col_ok && (col == ZERO_COL);
         m.digit = NO_DIGIT;
      end else begin
         m.hit   = row_ok && col_ok;
         m.digit = {2'b00, row} * 4'd3 + {2'b00, col} + 4'd1;
      end
      return m;
   endfunction

   // Keep the left entry on ties, so the lower digit wins.
   function automatic leader_type pick_leader(input leader_type a, input leader_type b);
      return (a.votes >= b.votes) ? a : b;
   endfunction

endpackage

// File: rtl/core/dtmf_spectral_peak_detector.sv
`timescale 1ns / 1ps
// Top level of the DTMF spectral peak detector: peak search, digit voting, window report.
//
// Usage:
//   req channel: one transform bin per transfer (bin_index, bin_magnitude). The bin whose
//   index is the last bin of the frame closes the frame: the low and high band peaks are
//   matched to a keypad digit and that digit's vote counter rises (saturating at 15).
//   rsp channel: after frames_per_window frames (0 acts as 1) one transfer reports the
//   most-voted digit, lowest digit on ties, or tone_found = 0 with zero fields; the votes
//   and frame count then clear. csr port: APB-style, registers at byte addresses
//   0x0..0x10, which the user writes only while idle; the block does not enforce this.
// Timing:
//   A bin moves into the input register on its transfer and is processed from there;
//   a report is written into the result register when its bin is processed. One bin per
//   cycle is sustained while no report is held back, set by the single processing step
//   between the input register and the result register.
// Reset and stall:
//   Reset loads the register defaults, empties both registers and clears peaks, frame
//   count and votes. While rsp is stalled with a report waiting, bins that end no
//   window keep flowing; only a bin that would emit a new report holds and stalls req.
module dtmf_spectral_peak_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  dtmf_spd_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output dtmf_spd_pkg::rsp_type                 rsp_data,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [dtmf_spd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [dtmf_spd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dtmf_spd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import dtmf_spd_pkg::*;

   // Configuration registers
   logic [3:0]  frames_per_window_ff;
   logic [11:0] low_first_ff;
   logic [11:0] low_last_ff;
   logic [11:0] high_first_ff;
   logic [11:0] high_last_ff;

   // Input register
   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_data_ff;

   // Frame and window state
   logic [31:0] low_val_ff,  low_val_in;
   logic [11:0] low_bin_ff,  low_bin_in;
   logic [31:0] high_val_ff, high_val_in;
   logic [11:0] high_bin_ff, high_bin_in;
   logic [3:0]  frame_count_ff, frame_count_in;
   logic [3:0]  votes_ff [VOTE_SLOTS];
   logic [3:0]  votes_in [VOTE_SLOTS];

   // Result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   // Processing
   logic          in_low, in_high, low_wins, high_wins, is_last;
   logic [11:0]   low_bin_upd, high_bin_upd;
   match_type     match;
   logic [3:0]    votes_upd [VOTE_SLOTS];
   logic [3:0]    window, count_next;
   logic          report, process;
   leader_type    lvl1 [5];
   leader_type    lvl2 [3];
   leader_type    lvl3 [2];
   leader_type    leader;
   rsp_type       result;

   logic          csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // Register read back, zero extended
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_FRAMES_PER_WINDOW:   csr_prdata = CSR_DATA_W'(frames_per_window_ff);
         REG_LOW_BAND_FIRST_BIN:  csr_prdata = CSR_DATA_W'(low_first_ff);
         REG_LOW_BAND_LAST_BIN:   csr_prdata = CSR_DATA_W'(low_last_ff);
         REG_HIGH_BAND_FIRST_BIN: csr_prdata = CSR_DATA_W'(high_first_ff);
         REG_HIGH_BAND_LAST_BIN:  csr_prdata = CSR_DATA_W'(high_last_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_per_window_ff <= RESET_FRAMES_PER_WINDOW;
         low_first_ff         <= RESET_LOW_BAND_FIRST_BIN;
         low_last_ff          <= RESET_LOW_BAND_LAST_BIN;
         high_first_ff        <= RESET_HIGH_BAND_FIRST_BIN;
         high_last_ff         <= RESET_HIGH_BAND_LAST_BIN;
      end else if (csr_write && csr_pready) begin
         case (csr_index)
            REG_FRAMES_PER_WINDOW:   frames_per_window_ff <= csr_pwdata[3:0];
            REG_LOW_BAND_FIRST_BIN:  low_first_ff         <= csr_pwdata[11:0];
            REG_LOW_BAND_LAST_BIN:   low_last_ff          <= csr_pwdata[11:0];
            REG_HIGH_BAND_FIRST_BIN: high_first_ff        <= csr_pwdata[11:0];
            REG_HIGH_BAND_LAST_BIN:  high_last_ff         <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   // Peak search: the low band has priority over the high band
   assign in_low    = (in_data_ff.bin_index >= low_first_ff) &&
                      (in_data_ff.bin_index <= low_last_ff);
   assign in_high   = (in_data_ff.bin_index >= high_first_ff) &&
                      (in_data_ff.bin_index <= high_last_ff);
   assign low_wins  = in_low && (in_data_ff.bin_magnitude > low_val_ff);
   assign high_wins = !low_wins && in_high && (in_data_ff.bin_magnitude > high_val_ff);

   assign low_bin_upd  = low_wins  ? in_data_ff.bin_index : low_bin_ff;
   assign high_bin_upd = high_wins ? in_data_ff.bin_index : high_bin_ff;

   // Frame end: match the peaks as they stand after this bin
   assign is_last = (in_data_ff.bin_index == LAST_BIN);
   assign match   = match_digit(low_bin_upd, high_bin_upd);

   always_comb begin
      for (int i = 0; i < VOTE_SLOTS; i++) begin
         votes_upd[i] = votes_ff[i];
         if (is_last && match.hit && (match.digit == 4'(i)) && (votes_ff[i] != VOTE_MAX)) begin
            votes_upd[i] = votes_ff[i] + 4'd1;
         end
      end
   end

   assign window     = (frames_per_window_ff == 4'd0) ? 4'd1 : frames_per_window_ff;
   assign count_next = frame_count_ff + 4'd1;
   assign report     = is_last && (count_next >= window);

   // Hold a reporting bin only while the result register is occupied and rsp is stalled
   assign process   = in_valid_ff && (!report || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !process;

   // Registered-free tournament over the ten vote counters, lower digit wins ties
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         lvl1[i] = pick_leader('{votes: votes_upd[2*i],     digit: 4'(2*i)},
                               '{votes: votes_upd[2*i + 1], digit: 4'(2*i + 1)});
      end
      lvl2[0] = pick_leader(lvl1[0], lvl1[1]);
      lvl2[1] = pick_leader(lvl1[2], lvl1[3]);
      lvl2[2] = lvl1[4];
      lvl3[0] = pick_leader(lvl2[0], lvl2[1]);
      lvl3[1] = lvl2[2];
      leader  = pick_leader(lvl3[0], lvl3[1]);
   end

   always_comb begin
      result.tone_found = (leader.votes != 4'd0);
      result.digit      = result.tone_found ? leader.digit : NO_DIGIT;
      result.vote_total = leader.votes;
   end

   // Next state of the frame and window
   always_comb begin
      low_val_in     = low_val_ff;
      low_bin_in     = low_bin_ff;
      high_val_in    = high_val_ff;
      high_bin_in    = high_bin_ff;
      frame_count_in = frame_count_ff;
      for (int i = 0; i < VOTE_SLOTS; i++) begin
         votes_in[i] = votes_ff[i];
      end
      if (process) begin
         if (is_last) begin
            // drop the peaks once matched
            low_val_in     = '0;
            low_bin_in     = '0;
            high_val_in    = '0;
            high_bin_in    = '0;
            frame_count_in = report ? 4'd0 : count_next;
            for (int i = 0; i < VOTE_SLOTS; i++) begin
               votes_in[i] = report ? 4'd0 : votes_upd[i];
            end
         end else begin
            if (low_wins) begin
               low_val_in = in_data_ff.bin_magnitude;
            end
            if (high_wins) begin
               high_val_in = in_data_ff.bin_magnitude;
            end
            low_bin_in  = low_bin_upd;
            high_bin_in = high_bin_upd;
         end
      end
   end

   assign in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !process);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (process && report) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         low_val_ff     <= '0;
         low_bin_ff     <= '0;
         high_val_ff    <= '0;
         high_bin_ff    <= '0;
         frame_count_ff <= '0;
         for (int i = 0; i < VOTE_SLOTS; i++) begin
            votes_ff[i] <= '0;
         end
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         low_val_ff     <= low_val_in;
         low_bin_ff     <= low_bin_in;
         high_val_ff    <= high_val_in;
         high_bin_ff    <= high_bin_in;
         frame_count_ff <= frame_count_in;
         for (int i = 0; i < VOTE_SLOTS; i++) begin
            votes_ff[i] <= votes_in[i];
         end
      end
   end

   // Payload registers: advance on transfer or new report
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DTMF spectral peak detector: scripted and random frames.
module tb;
   import dtmf_spd_pkg::*;

   localparam int IDLE_LIMIT = 2000;   // cycles with no transfer before giving up
   localparam int ITEM_GOAL  = 1250;

   // One queued bin, with an optional fixed report typed into the script.
   typedef struct {
      req_type data;
      bit      typed;
      rsp_type want;
   } bin_job;

   // Row of the scripted part: bin, magnitude, fixed-report flag, fixed report.
   typedef struct packed {
      logic [11:0] bin;
      logic [31:0] mag;
      logic        typed;
      rsp_type     want;
   } script_row;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dtmf_spectral_peak_detector dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Mirror of the configuration registers, kept in step with every write.
   logic [3:0]  win_frames = RESET_FRAMES_PER_WINDOW;
   logic [11:0] lo_first   = RESET_LOW_BAND_FIRST_BIN;
   logic [11:0] lo_last    = RESET_LOW_BAND_LAST_BIN;
   logic [11:0] hi_first   = RESET_HIGH_BAND_FIRST_BIN;
   logic [11:0] hi_last    = RESET_HIGH_BAND_LAST_BIN;

   // Predicted detector state: band peaks, frame count and digit votes.
   logic [31:0] low_mag = '0;
   logic [11:0] low_bin = '0;
   logic [31:0] high_mag = '0;
   logic [11:0] high_bin = '0;
   logic [3:0]  frames_seen = '0;
   logic [3:0]  votes [VOTE_SLOTS];

   logic [11:0] row_bins [4] = '{ROW_BIN_0, ROW_BIN_1, ROW_BIN_2, ROW_BIN_3};
   logic [11:0] col_bins [3] = '{COL_BIN_0, COL_BIN_1, COL_BIN_2};

   bin_job  bin_jobs [$];          // bins waiting to be driven
   rsp_type pending_reports [$];   // window reports still owed by the block
   bin_job  on_wire;
   bit      failed = 1'b0;
   int      items_sent = 0;
   int      idle_cycles = 0;

   // Scripted opening: five frames under the reset settings with a tie of single
   // votes (lowest digit wins), then a window of bare frame ends that reports no tone.
   script_row script [22] = '{
      {12'd66,   32'hFFFF_FFFF, 1'b0, 9'h0},      // digit 5, widest low peak
      {12'd114,  32'h0000_0010, 1'b0, 9'h0},
      {LAST_BIN, 32'h0000_0000, 1'b0, 9'h0},
      {12'd80,   32'h0000_0005, 1'b0, 9'h0},      // bottom row, middle column: digit 0
      {12'd114,  32'h0000_0007, 1'b0, 9'h0},
      {LAST_BIN, 32'h0000_0000, 1'b0, 9'h0},
      {12'd60,   32'h0000_0009, 1'b0, 9'h0},      // equal peaks: the first one holds
      {12'd66,   32'h0000_0009, 1'b0, 9'h0},
      {12'd126,  32'h0000_0001, 1'b0, 9'h0},
      {LAST_BIN, 32'h0000_0000, 1'b0, 9'h0},
      {12'd0,    32'hFFFF_FFFF, 1'b0, 9'h0},      // outside both bands
      {12'd80,   32'h0000_0003, 1'b0, 9'h0},      // bottom row with first column: no digit
      {12'd104,  32'h0000_0003, 1'b0, 9'h0},
      {LAST_BIN, 32'h0000_0000, 1'b0, 9'h0},
      {12'd60,   32'h0000_0000, 1'b0, 9'h0},      // zero magnitudes never take a peak
      {12'd104,  32'h0000_0000, 1'b0, 9'h0},
      {LAST_BIN, 32'hFFFF_FFFF, 1'b1, {1'b1, 4'd0, 4'd1}},
      {LAST_BIN, 32'h0000_0000, 1'b0, 9'h0},
      {LAST_BIN, 32'h0000_0001, 1'b0, 9'h0},
      {LAST_BIN, 32'h0000_0002, 1'b0, 9'h0},
      {LAST_BIN, 32'h0000_0003, 1'b0, 9'h0},
      {LAST_BIN, 32'h1234_5678, 1'b1, {1'b0, 4'd0, 4'd0}}
   };

   initial begin
      for (int i = 0; i < VOTE_SLOTS; i++) votes[i] = '0;
   end

   // Keypad digit for a row/column peak pair, or -1 when the pair is not a key.
   function automatic int keypad_digit(logic [11:0] lb, logic [11:0] hb);
      int row;
      int col;
      row = -1;
      col = -1;
      for (int r = 0; r < 4; r++) if (lb == row_bins[r]) row = r;
      for (int c = 0; c < 3; c++) if (hb == col_bins[c]) col = c;
      if (row < 0 || col < 0) return -1;
      if (row < 3) return row * 3 + col + 1;
      return (col == 1) ? 0 : -1;
   endfunction

   // Advance the predicted state by one bin; flag a report when a window closes.
   task automatic tally_bin(input req_type b, output bit emits, output rsp_type rep);
      bit         in_lo;
      bit         in_hi;
      int         d;
      logic [3:0] window;
      logic [3:0] best;
      logic [3:0] best_digit;
      emits = 1'b0;
      rep = '0;
      in_lo = b.bin_index >= lo_first && b.bin_index <= lo_last;
      in_hi = b.bin_index >= hi_first && b.bin_index <= hi_last;
      // Low band has priority; the high band sees the bin only if the low one passes.
      if (in_lo && b.bin_magnitude > low_mag) begin
         low_mag = b.bin_magnitude;
         low_bin = b.bin_index;
      end else if (in_hi && b.bin_magnitude > high_mag) begin
         high_mag = b.bin_magnitude;
         high_bin = b.bin_index;
      end
      if (b.bin_index != LAST_BIN) return;
      d = keypad_digit(low_bin, high_bin);
      if (d >= 0 && votes[d] != VOTE_MAX) votes[d] = votes[d] + 4'd1;
      low_mag = '0;
      low_bin = '0;
      high_mag = '0;
      high_bin = '0;
      window = (win_frames == 4'd0) ? 4'd1 : win_frames;
      frames_seen = frames_seen + 4'd1;
      if (frames_seen < window) return;
      best = '0;
      best_digit = '0;
      for (int i = 0; i < VOTE_SLOTS; i++) begin
         if (votes[i] > best) begin
            best = votes[i];
            best_digit = 4'(i);
         end
      end
      emits = 1'b1;
      rep.tone_found = (best != 0);
      rep.digit = (best != 0) ? best_digit : NO_DIGIT;
      rep.vote_total = best;
      for (int i = 0; i < VOTE_SLOTS; i++) votes[i] = '0;
      frames_seen = '0;
   endtask

   // Sender: transfer queued bins in bursts of random length with random gaps.
   bit      bin_emits;
   rsp_type bin_report;
   int      burst_left = 1;
   int      gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left = 0;
      end else begin
         // Predict on the transfer; a scripted fixed report overrides the prediction.
         if (req_valid && !req_stall) begin
            tally_bin(on_wire.data, bin_emits, bin_report);
            if (on_wire.typed) pending_reports.push_back(on_wire.want);
            else if (bin_emits) pending_reports.push_back(bin_report);
         end
         // Hold a stalled bin; otherwise load the next one or idle.
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (bin_jobs.size() > 0) begin
               on_wire = bin_jobs.pop_front();
               req_valid <= 1'b1;
               req_data <= on_wire.data;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall in runs of random length, each run stalled or free at random.
   bit stalling = 1'b0;
   int stall_run = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else begin
         if (stall_run == 0) begin
            stalling = ($urandom_range(0, 2) == 0);
            stall_run = stalling ? $urandom_range(1, 8) : $urandom_range(1, 15);
         end
         stall_run--;
         rsp_stall <= stalling;
      end
   end

   function automatic void flag_field(string name, int want, int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
   endfunction

   // Compare every report transfer with the oldest owed report.
   rsp_type oldest;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual %h", $time, rsp_data);
            failed = 1'b1;
         end else begin
            oldest = pending_reports.pop_front();
            if (rsp_data.tone_found !== oldest.tone_found)
               flag_field("tone_found", oldest.tone_found, rsp_data.tone_found);
            if (rsp_data.digit !== oldest.digit)
               flag_field("digit", oldest.digit, rsp_data.digit);
            if (rsp_data.vote_total !== oldest.vote_total)
               flag_field("vote_total", oldest.vote_total, rsp_data.vote_total);
         end
      end
   end

   // Watchdog: end the run when nothing transfers for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One register access: setup phase, access phase, then a quiet phase with psel low.
   task automatic csr_access(input reg_index_type r, input bit wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_register(input reg_index_type r, input logic [31:0] want);
      logic [31:0] got;
      csr_access(r, 1'b0, '0, got);
      if (got !== want) begin
         $display("%0t: register %s readback, expected %h, actual %h", $time, r.name(),
                  want, got);
         failed = 1'b1;
      end
   endtask

   task automatic set_register(input reg_index_type r, input logic [31:0] v);
      logic [31:0] unused;
      csr_access(r, 1'b1, v, unused);
      case (r)
         REG_FRAMES_PER_WINDOW:   win_frames = v[3:0];
         REG_LOW_BAND_FIRST_BIN:  lo_first = v[11:0];
         REG_LOW_BAND_LAST_BIN:   lo_last = v[11:0];
         REG_HIGH_BAND_FIRST_BIN: hi_first = v[11:0];
         REG_HIGH_BAND_LAST_BIN:  hi_last = v[11:0];
         default: ;
      endcase
      read_register(r, r == REG_FRAMES_PER_WINDOW ? {28'h0, v[3:0]} : {20'h0, v[11:0]});
   endtask

   function automatic req_type mk_bin(logic [11:0] bin, logic [31:0] mag);
      req_type b;
      b.bin_index = bin;
      b.bin_magnitude = mag;
      return b;
   endfunction

   task automatic queue_bin(input req_type b);
      bin_job j;
      j.data = b;
      j.typed = 1'b0;
      j.want = '0;
      bin_jobs.push_back(j);
      items_sent++;
   endtask

   // Peak level that beats any noise bin below bit 31.
   function automatic logic [31:0] strong_level();
      return ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
   endfunction

   // Queue one frame: mostly a keyed row/column pair among noise, in shuffled order,
   // sometimes pure noise or silence; the last bin closes it.
   task automatic queue_frame();
      req_type     parts [$];
      req_type     tmp;
      int          pick;
      int          d;
      int          row;
      int          col;
      int          n;
      int          j;
      logic [31:0] lo_m;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         n = $urandom_range(1, 5);
         repeat (n) parts.push_back(mk_bin(12'($urandom), $urandom));
      end else if (pick < 11) begin
         parts.push_back(mk_bin(ROW_BIN_1, 32'd0));
         parts.push_back(mk_bin(COL_BIN_1, 32'd0));
      end else begin
         // Pick a key; one slot stands for the bottom row with an outer column.
         d = $urandom_range(0, 10);
         if (d == 10) begin
            row = 3;
            col = $urandom_range(0, 1) * 2;
         end else if (d == 0) begin
            row = 3;
            col = 1;
         end else begin
            row = (d - 1) / 3;
            col = (d - 1) % 3;
         end
         lo_m = strong_level();
         parts.push_back(mk_bin(row_bins[row], lo_m));
         parts.push_back(mk_bin(col_bins[col], strong_level()));
         n = $urandom_range(0, 4);
         repeat (n) begin
            tmp.bin_index = ($urandom_range(0, 9) < 7) ? 12'($urandom_range(56, 130))
                                                       : 12'($urandom_range(0, 4094));
            tmp.bin_magnitude = ($urandom_range(0, 9) == 0) ? lo_m
                                                           : $urandom_range(0, 32'h7FFF_FFFF);
            parts.push_back(tmp);
         end
      end
      for (int i = parts.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = parts[i];
         parts[i] = parts[j];
         parts[j] = tmp;
      end
      foreach (parts[i]) queue_bin(parts[i]);
      queue_bin(mk_bin(LAST_BIN, $urandom));
   endtask

   // Settings for one random phase; the first phases hit the extremes.
   task automatic pick_settings(input int p);
      int          fpw;
      int          mode;
      logic [11:0] lf;
      logic [11:0] ll;
      logic [11:0] hf;
      logic [11:0] hl;
      fpw = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 15);
      mode = $urandom_range(0, 19);
      mode = (mode < 12) ? 0 : (mode < 15) ? 1 : (mode < 17) ? 2 : 3;
      case (p)
         0: begin fpw = 15; mode = 0; end
         1: begin fpw = 0;  mode = 3; end
         2: begin fpw = 1;  mode = 2; end
         3: mode = 1;
         default: ;
      endcase
      case (mode)
         0: begin   // bands around the keypad bins
            lf = 12'($urandom_range(40, 60));
            ll = 12'($urandom_range(80, 100));
            hf = 12'($urandom_range(101, 104));
            hl = 12'($urandom_range(126, 200));
         end
         1: begin   // overlapping bands: low band takes priority
            lf = 12'($urandom_range(40, 70));
            ll = 12'($urandom_range(100, 130));
            hf = 12'($urandom_range(60, 104));
            hl = 12'($urandom_range(114, 140));
         end
         2: begin   // empty low band
            lf = 12'hFFF;
            ll = 12'h000;
            hf = COL_BIN_0;
            hl = COL_BIN_2;
         end
         default: begin
            if (p == 1) begin   // both bands span every bin
               lf = 12'h000;
               ll = 12'hFFF;
               hf = 12'h000;
               hl = 12'hFFF;
            end else begin
               lf = 12'($urandom);
               ll = 12'($urandom);
               hf = 12'($urandom);
               hl = 12'($urandom);
            end
         end
      endcase
      set_register(REG_FRAMES_PER_WINDOW, 32'(fpw));
      set_register(REG_LOW_BAND_FIRST_BIN, {20'h0, lf});
      set_register(REG_LOW_BAND_LAST_BIN, {20'h0, ll});
      set_register(REG_HIGH_BAND_FIRST_BIN, {20'h0, hf});
      set_register(REG_HIGH_BAND_LAST_BIN, {20'h0, hl});
   endtask

   // Wait until every bin is transferred and every owed report is in, then let a
   // bin still in flight settle.
   task automatic wait_drained();
      while (bin_jobs.size() != 0 || req_valid || pending_reports.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      bin_job      j;
      int          p;
      int          phase_goal;
      int          phase_start;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Check the reset values of every register.
      read_register(REG_FRAMES_PER_WINDOW,   {28'h0, RESET_FRAMES_PER_WINDOW});
      read_register(REG_LOW_BAND_FIRST_BIN,  {20'h0, RESET_LOW_BAND_FIRST_BIN});
      read_register(REG_LOW_BAND_LAST_BIN,   {20'h0, RESET_LOW_BAND_LAST_BIN});
      read_register(REG_HIGH_BAND_FIRST_BIN, {20'h0, RESET_HIGH_BAND_FIRST_BIN});
      read_register(REG_HIGH_BAND_LAST_BIN,  {20'h0, RESET_HIGH_BAND_LAST_BIN});

      // Walk the script under the reset settings.
      foreach (script[i]) begin
         j.data = mk_bin(script[i].bin, script[i].mag);
         j.typed = script[i].typed;
         j.want = script[i].want;
         bin_jobs.push_back(j);
         items_sent++;
      end
      wait_drained();

      // Random phases, each under fresh settings written while the block is idle.
      p = 0;
      while (items_sent < ITEM_GOAL) begin
         pick_settings(p);
         phase_goal = $urandom_range(30, 90);
         phase_start = items_sent;
         while (items_sent - phase_start < phase_goal) queue_frame();
         wait_drained();
         p++;
      end

      repeat (8) @(posedge clock);
      if (!failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/dtmf_spd_pkg.sv
rtl/core/dtmf_spectral_peak_detector.sv
sim/tb.sv
